### rtl/usl_pkg.sv
// Shared types and constants for the shared-line 8N1 serial transceiver.
package usl_pkg;

    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_BIT_TICKS = 3'd0;
    localparam logic [15:0] BIT_TICKS_RESET = 16'd104;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    typedef struct packed {
        logic tx_level;
        logic tx_busy;
        logic send_dropped;
    } tx_res_t;

    typedef struct packed {
        logic       rx_valid;
        logic [7:0] rx_byte;
    } rx_res_t;

endpackage

### rtl/uart_8n1_shared_line.sv
// Top level: 8N1 serial transceiver sharing its line with a sensor chip.
//
// Every input transaction is one timing tick and yields exactly one result
// transaction. The block takes one tick per clock cycle unless a full output
// register waits on m_axis_tready; transmitter and receiver state advance on
// each accepted tick and the result lands in an output register, which is
// refilled in the same cycle it is drained. The result is valid in the cycle
// after its tick is accepted. Register bit_ticks (byte address 0) sets the
// ticks per serial bit; values below 2 act as 2 and values beyond the timer
// range act as the largest timer value. Write it only while no tick is in flight.
module uart_8n1_shared_line
    import usl_pkg::*;
#(
    parameter int DATA_BITS   = 8,
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // rx_level[0], send_valid[1], send_byte[9:2], sensor_owns_line[10], zero[15:11]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // tx_level[0], sensor_owns_line[1], tx_busy[2], send_dropped[3], rx_valid[4],
    // rx_byte[12:5], zero[15:13]
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam logic [CW-1:0] TIMER_MAX = CW'({TIMER_WIDTH{1'b1}});

    logic [15:0]            bit_ticks_reg;
    logic [CW-1:0]          ticks_wide;
    logic [TIMER_WIDTH-1:0] ticks;
    logic                   accept;
    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg, out_data_next;
    logic                   rx_level, send_valid, owned;
    logic [7:0]             send_byte;
    tx_res_t                tx_res;
    rx_res_t                rx_res;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BIT_TICKS) ? {16'd0, bit_ticks_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg <= BIT_TICKS_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == REG_BIT_TICKS)
        begin
            bit_ticks_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        ticks_wide = CW'(bit_ticks_reg);
        if (ticks_wide < CW'(2))
        begin
            ticks_wide = CW'(2);
        end
        else if (ticks_wide > TIMER_MAX)
        begin
            ticks_wide = TIMER_MAX;
        end
        ticks = ticks_wide[TIMER_WIDTH-1:0];
    end

    assign rx_level   = s_axis_tdata[0];
    assign send_valid = s_axis_tdata[1];
    assign send_byte  = s_axis_tdata[9:2];
    assign owned      = s_axis_tdata[10];

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    usl_tx #(
        .DATA_BITS   (DATA_BITS),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .send_valid (send_valid),
        .send_byte  (send_byte),
        .owned      (owned),
        .ticks      (ticks),
        .res        (tx_res)
    );

    usl_rx #(
        .DATA_BITS   (DATA_BITS),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_rx (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (accept),
        .rx_level (rx_level),
        .owned    (owned),
        .ticks    (ticks),
        .res      (rx_res)
    );

    assign out_data_next = {3'd0, rx_res.rx_byte, rx_res.rx_valid, tx_res.send_dropped,
                            tx_res.tx_busy, owned, tx_res.tx_level};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

### rtl/usl_tx.sv
// 8N1 transmitter state: bit counter, data shifter and bit timer.
module usl_tx
    import usl_pkg::*;
#(
    parameter int DATA_BITS   = 8,
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   send_valid,
    input  logic [7:0]             send_byte,
    input  logic                   owned,
    input  logic [TIMER_WIDTH-1:0] ticks,
    output tx_res_t                res
);

    localparam int IW = $clog2(DATA_BITS + 3);
    localparam int SW = $clog2(DATA_BITS);
    localparam logic [IW-1:0] STOP = IW'(DATA_BITS + 2);
    localparam logic [IW-1:0] START = IW'(1);
    localparam logic [IW-1:0] IDLE = '0;

    logic [IW-1:0]          idx_reg, idx_next;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [TIMER_WIDTH-1:0] timer_inc;
    logic [IW-1:0]          bit_sel;
    logic                   dropped;
    logic                   level;

    always_comb
    begin
        idx_next   = idx_reg;
        shift_next = shift_reg;
        timer_next = timer_reg;
        dropped    = 1'b0;
        timer_inc  = timer_reg + 1'b1;
        if (idx_reg != IDLE)
        begin
            dropped    = send_valid;
            timer_next = timer_inc;
            if (timer_inc >= ticks)
            begin
                timer_next = '0;
                idx_next   = (idx_reg == STOP) ? IDLE : idx_reg + 1'b1;
            end
        end
        else if (send_valid)
        begin
            if (owned)
            begin
                dropped = 1'b1;
            end
            else
            begin
                shift_next = DATA_BITS'(send_byte);
                timer_next = '0;
                idx_next   = START;
            end
        end
    end

    always_comb
    begin
        bit_sel = idx_next - IW'(2);
        if (idx_next == IDLE || idx_next == STOP)
        begin
            level = 1'b1;
        end
        else if (idx_next == START)
        begin
            level = 1'b0;
        end
        else
        begin
            level = shift_next[bit_sel[SW-1:0]];
        end
    end

    assign res.tx_level     = level;
    assign res.tx_busy      = (idx_next != IDLE);
    assign res.send_dropped = dropped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            shift_reg <= '0;
            timer_reg <= '0;
        end
        else if (advance)
        begin
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            timer_reg <= timer_next;
        end
    end

endmodule

### rtl/usl_rx.sv
// 8N1 receiver state: start detect, mid-bit sampling and stop bit wait.
module usl_rx
    import usl_pkg::*;
#(
    parameter int DATA_BITS   = 8,
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic                   rx_level,
    input  logic                   owned,
    input  logic [TIMER_WIDTH-1:0] ticks,
    output rx_res_t                res
);

    localparam int IW = $clog2(DATA_BITS + 3);
    localparam int SW = $clog2(DATA_BITS);
    localparam logic [IW-1:0] STOP = IW'(DATA_BITS + 2);
    localparam logic [IW-1:0] START = IW'(1);
    localparam logic [IW-1:0] FIRST_DATA = IW'(2);
    localparam logic [IW-1:0] IDLE = '0;

    logic [IW-1:0]          idx_reg, idx_next;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [TIMER_WIDTH-1:0] timer_inc;
    logic [TIMER_WIDTH-1:0] half;
    logic [IW-1:0]          bit_sel;
    logic                   valid;

    always_comb
    begin
        idx_next   = idx_reg;
        shift_next = shift_reg;
        timer_next = timer_reg;
        valid      = 1'b0;
        timer_inc  = timer_reg + 1'b1;
        half       = ticks >> 1;
        bit_sel    = idx_reg - FIRST_DATA;
        if (idx_reg == IDLE)
        begin
            if (!owned && !rx_level)
            begin
                idx_next   = START;
                timer_next = '0;
                shift_next = '0;
            end
        end
        else if (idx_reg == START)
        begin
            timer_next = timer_inc;
            if (timer_inc >= half)
            begin
                timer_next = '0;
                idx_next   = FIRST_DATA;
            end
        end
        else
        begin
            timer_next = timer_inc;
            if (timer_inc >= ticks)
            begin
                timer_next = '0;
                if (idx_reg < STOP)
                begin
                    if (rx_level)
                    begin
                        shift_next[bit_sel[SW-1:0]] = 1'b1;
                    end
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    valid    = 1'b1;
                    idx_next = IDLE;
                end
            end
        end
    end

    assign res.rx_valid = valid;
    assign res.rx_byte  = valid ? 8'(shift_reg) : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            shift_reg <= '0;
            timer_reg <= '0;
        end
        else if (advance)
        begin
            idx_reg   <= idx_next;
            shift_reg <= shift_next;
            timer_reg <= timer_next;
        end
    end

endmodule
